/* rtl/iqmg_pkg.sv */
// iqmg_pkg: shared types, constants and sine table for the iq modulation generator
// no dependencies
package iqmg_pkg;

    localparam int unsigned SINE_MID  = 2048;
    localparam int unsigned SINE_FULL = 2047;
    localparam int unsigned PERCENT   = 100;
    localparam logic [15:0] PRBS_SEED = 16'h5A5A;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    // register indexes
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_PEAK   = 3'd1;
    localparam logic [2:0] REG_DEPTH  = 3'd2;
    localparam logic [2:0] REG_MSTEP  = 3'd3;
    localparam logic [2:0] REG_DEV    = 3'd4;
    localparam logic [2:0] REG_FSK    = 3'd5;
    localparam logic [2:0] REG_SPS    = 3'd6;
    localparam logic [2:0] REG_LFSR   = 3'd7;

    // mode codes
    localparam logic [2:0] MODE_AM  = 3'd0;
    localparam logic [2:0] MODE_FM  = 3'd1;
    localparam logic [2:0] MODE_ASK = 3'd2;
    localparam logic [2:0] MODE_PSK = 3'd3;

    // multiply-divide request to the shared unit
    typedef struct packed {
        logic               start;
        logic signed [31:0] a;      // signed multiplicand
        logic        [11:0] b;      // unsigned multiplier
        logic               pct;    // divide by 100 after the divide by 2047
    } t_md_req;

    typedef struct packed {
        logic               done;
        logic signed [43:0] q;      // truncated quotient
    } t_md_rsp;

    localparam logic [11:0] SINE_ROM [256] = '{
        12'd2048,12'd2098,12'd2148,12'd2198,12'd2248,12'd2298,12'd2348,12'd2398,
        12'd2447,12'd2496,12'd2545,12'd2594,12'd2642,12'd2690,12'd2737,12'd2784,
        12'd2831,12'd2877,12'd2923,12'd2968,12'd3013,12'd3057,12'd3100,12'd3143,
        12'd3185,12'd3226,12'd3267,12'd3307,12'd3346,12'd3385,12'd3423,12'd3459,
        12'd3495,12'd3530,12'd3565,12'd3598,12'd3630,12'd3662,12'd3692,12'd3722,
        12'd3750,12'd3777,12'd3804,12'd3829,12'd3853,12'd3876,12'd3898,12'd3919,
        12'd3939,12'd3958,12'd3975,12'd3992,12'd4007,12'd4021,12'd4034,12'd4045,
        12'd4056,12'd4065,12'd4073,12'd4080,12'd4085,12'd4089,12'd4093,12'd4094,
        12'd4095,12'd4094,12'd4093,12'd4089,12'd4085,12'd4080,12'd4073,12'd4065,
        12'd4056,12'd4045,12'd4034,12'd4021,12'd4007,12'd3992,12'd3975,12'd3958,
        12'd3939,12'd3919,12'd3898,12'd3876,12'd3853,12'd3829,12'd3804,12'd3777,
        12'd3750,12'd3722,12'd3692,12'd3662,12'd3630,12'd3598,12'd3565,12'd3530,
        12'd3495,12'd3459,12'd3423,12'd3385,12'd3346,12'd3307,12'd3267,12'd3226,
        12'd3185,12'd3143,12'd3100,12'd3057,12'd3013,12'd2968,12'd2923,12'd2877,
        12'd2831,12'd2784,12'd2737,12'd2690,12'd2642,12'd2594,12'd2545,12'd2496,
        12'd2447,12'd2398,12'd2348,12'd2298,12'd2248,12'd2198,12'd2148,12'd2098,
        12'd2048,12'd1997,12'd1947,12'd1897,12'd1847,12'd1797,12'd1747,12'd1697,
        12'd1648,12'd1599,12'd1550,12'd1501,12'd1453,12'd1405,12'd1358,12'd1311,
        12'd1264,12'd1218,12'd1172,12'd1127,12'd1082,12'd1038,12'd995, 12'd952,
        12'd910, 12'd869, 12'd828, 12'd788, 12'd749, 12'd710, 12'd672, 12'd636,
        12'd600, 12'd565, 12'd530, 12'd497, 12'd465, 12'd433, 12'd403, 12'd373,
        12'd345, 12'd318, 12'd291, 12'd266, 12'd242, 12'd219, 12'd197, 12'd176,
        12'd156, 12'd137, 12'd120, 12'd103, 12'd88,  12'd74,  12'd61,  12'd50,
        12'd39,  12'd30,  12'd22,  12'd15,  12'd10,  12'd6,   12'd2,   12'd1,
        12'd0,   12'd1,   12'd2,   12'd6,   12'd10,  12'd15,  12'd22,  12'd30,
        12'd39,  12'd50,  12'd61,  12'd74,  12'd88,  12'd103, 12'd120, 12'd137,
        12'd156, 12'd176, 12'd197, 12'd219, 12'd242, 12'd266, 12'd291, 12'd318,
        12'd345, 12'd373, 12'd403, 12'd433, 12'd465, 12'd497, 12'd530, 12'd565,
        12'd600, 12'd636, 12'd672, 12'd710, 12'd749, 12'd788, 12'd828, 12'd869,
        12'd910, 12'd952, 12'd995, 12'd1038,12'd1082,12'd1127,12'd1172,12'd1218,
        12'd1264,12'd1311,12'd1358,12'd1405,12'd1453,12'd1501,12'd1550,12'd1599,
        12'd1648,12'd1697,12'd1747,12'd1797,12'd1847,12'd1897,12'd1947,12'd1997
    };

    // signed sine sample, -2048..2047
    function automatic logic signed [12:0] sine_of(input logic [31:0] phase);
        sine_of = $signed({1'b0, SINE_ROM[phase[31:24]]}) - 13'sd2048;
    endfunction

endpackage

/* rtl/iq_baseband_modulation_generator_core.sv */
// iq_baseband_modulation_generator_core: top level, registers, sequencer, symbol source
// depends on iqmg_pkg and iqmg_muldiv
//
// One request produces one I/Q pair of 12-bit dac codes. Work is done by a single
// shared multiply-and-divide unit (one product, then a divide by 2047 that folds the
// high bits onto the low bits, up to four fold steps and a final compare, then for AM
// a divide by 100 by reciprocal multiply). Unit passes per request: ASK/PSK none, AM
// one, FSK/CW two, FM three. o_stall is high while a request is in work; a finished
// pair waits in the output register while the next request is already being computed.
module iq_baseband_modulation_generator_core #(
    parameter int DC_OFFSET_CODE = 496
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_i_code,
    output logic [11:0] o_q_code
);
    import iqmg_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PREP = 6'b000010,
        S_DEV  = 6'b000100,
        S_IC   = 6'b001000,
        S_QC   = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    // configuration
    logic [2:0]  r_mode;
    logic [11:0] r_peak;
    logic [6:0]  r_depth;
    logic [31:0] r_mstep;
    logic [30:0] r_dev;
    logic [31:0] r_fsk;
    logic [23:0] r_sps;
    logic        r_use_lfsr;

    // generator state
    logic [31:0] r_cphase;
    logic [31:0] r_mphase;
    logic [23:0] r_count;
    logic [15:0] r_prbs;
    logic        r_bit;

    t_state      r_state;
    logic        r_wait;     // a unit pass is running
    logic signed [14:0] r_ival;
    logic signed [14:0] r_qval;
    logic        r_ovalid;
    logic [11:0] r_icode;
    logic [11:0] r_qcode;

    t_md_req     w_req;
    t_md_rsp     w_rsp;

    iqmg_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // symbol bit update as a function of current symbol state
    logic [15:0] w_prbs_n;
    logic        w_bit_n;
    logic [23:0] w_count_n;
    logic        w_fb;
    always_comb begin
        w_fb      = r_prbs[0] ^ r_prbs[2] ^ r_prbs[3] ^ r_prbs[5];
        w_prbs_n  = r_prbs;
        w_bit_n   = r_bit;
        w_count_n = r_count;
        if (r_count == '0) begin
            if (r_use_lfsr) begin
                w_prbs_n = {w_fb, r_prbs[15:1]};
                w_bit_n  = w_prbs_n[0];
            end else begin
                w_bit_n = ~r_bit;
            end
            w_count_n = (r_sps == '0) ? 24'd1 : r_sps;
        end
        w_count_n = w_count_n - 24'd1;
    end

    logic w_am;
    logic w_fm;
    logic w_key;   // ask or psk
    assign w_am  = (r_mode == MODE_AM);
    assign w_fm  = (r_mode == MODE_FM);
    assign w_key = (r_mode == MODE_ASK) || (r_mode == MODE_PSK);

    // clamp helper
    function automatic logic [11:0] to_code(input logic signed [14:0] v);
        logic signed [15:0] c;
        c = 16'(DC_OFFSET_CODE) + 16'(v);
        if (c < 0)          to_code = 12'd0;
        else if (c > 4095)  to_code = 12'd4095;
        else                to_code = c[11:0];
    endfunction

    // requests to the unit, issued on entry to each compute state
    logic               w_start;
    logic signed [31:0] w_a;
    logic [11:0]        w_b;
    logic               w_pct;
    logic signed [12:0] w_sin_m;
    always_comb begin
        w_sin_m = sine_of(r_mphase);
        w_a = '0;
        w_b = '0;
        w_pct = 1'b0;
        case (r_state)
            S_DEV: begin
                if (w_am) begin
                    w_a = 32'(w_sin_m) * $signed({25'd0, r_depth});
                    w_b = r_peak;
                    w_pct = 1'b1;
                end else begin
                    w_a = 32'(w_sin_m);
                    w_b = 12'd0;
                end
            end
            S_IC: begin
                w_a = 32'(sine_of(r_cphase + QUARTER_TURN));
                w_b = r_peak;
            end
            S_QC: begin
                w_a = 32'(sine_of(r_cphase));
                w_b = r_peak;
            end
            default: ;
        endcase
        w_start = !r_wait && (r_state == S_DEV || r_state == S_IC || r_state == S_QC);
    end

    // fm deviation: dev (31b) does not fit the 12-bit b operand, so form sine*dev in one
    // 32x12 pass via a = dev, b = |sine|, sign applied after
    logic signed [12:0] r_fm_sin;
    always_comb begin
        w_req.start = w_start;
        w_req.a     = w_a;
        w_req.b     = w_b;
        w_req.pct   = w_pct;
        if (r_state == S_DEV && w_fm) begin
            w_req.a = $signed({1'b0, r_dev});
            w_req.b = w_sin_m[12] ? 12'(-w_sin_m) : w_sin_m[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= '0;
            r_peak     <= '0;
            r_depth    <= '0;
            r_mstep    <= '0;
            r_dev      <= '0;
            r_fsk      <= '0;
            r_sps      <= 24'd1;
            r_use_lfsr <= 1'b0;
            r_cphase   <= '0;
            r_mphase   <= '0;
            r_count    <= '0;
            r_prbs     <= PRBS_SEED;
            r_bit      <= 1'b1;
            r_state    <= S_IDLE;
            r_wait     <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MODE:  r_mode     <= i_cfg_data[2:0];
                    REG_PEAK:  r_peak     <= i_cfg_data[11:0];
                    REG_DEPTH: r_depth    <= i_cfg_data[6:0];
                    REG_MSTEP: r_mstep    <= i_cfg_data;
                    REG_DEV:   r_dev      <= i_cfg_data[30:0];
                    REG_FSK:   r_fsk      <= i_cfg_data;
                    REG_SPS:   r_sps      <= i_cfg_data[23:0];
                    REG_LFSR:  r_use_lfsr <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (w_start) r_wait <= 1'b1;
            if (w_rsp.done) r_wait <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        if (i_restart) begin
                            r_cphase <= '0;
                            r_mphase <= '0;
                            r_count  <= '0;
                            r_prbs   <= PRBS_SEED;
                            r_bit    <= 1'b1;
                        end
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_qval <= '0;
                    if (w_am || w_fm) begin
                        r_fm_sin <= sine_of(r_mphase);
                        r_state  <= S_DEV;
                    end else begin
                        r_prbs  <= w_prbs_n;
                        r_bit   <= w_bit_n;
                        r_count <= w_count_n;
                        if (w_key) begin
                            r_ival  <= (r_mode == MODE_ASK) ?
                                       (w_bit_n ? 15'(r_peak) : 15'sd0) :
                                       (w_bit_n ? 15'(r_peak) : -15'(r_peak));
                            r_state <= S_OUT;
                        end else begin
                            r_cphase <= w_bit_n ? r_cphase + r_fsk : r_cphase - r_fsk;
                            r_state  <= S_IC;
                        end
                    end
                end
                S_DEV: begin
                    if (w_rsp.done) begin
                        r_mphase <= r_mphase + r_mstep;
                        if (w_am) begin
                            r_ival  <= 15'(r_peak) + 15'(w_rsp.q);
                            r_state <= S_OUT;
                        end else begin
                            r_cphase <= r_fm_sin[12] ? r_cphase - 32'(w_rsp.q)
                                                     : r_cphase + 32'(w_rsp.q);
                            r_state  <= S_IC;
                        end
                    end
                end
                S_IC: begin
                    if (w_rsp.done) begin
                        r_ival  <= 15'(w_rsp.q);
                        r_state <= S_QC;
                    end
                end
                S_QC: begin
                    if (w_rsp.done) begin
                        r_qval  <= 15'(w_rsp.q);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // wait here while the previous pair is still held
                    if (!r_ovalid) begin
                        r_icode  <= to_code(r_ival);
                        r_qcode  <= to_code(r_qval);
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_i_code = r_icode;
    assign o_q_code = r_qcode;

    // a stalled result holds its codes
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> (r_ovalid && $stable(r_icode) && $stable(r_qcode)))
        else $error("stalled result changed");
    // unit finishes only while a compute state waits on it
    a_done_in_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_DEV || r_state == S_IC || r_state == S_QC))
        else $error("unit result with no consumer");
    // result appears only after the output state
    a_out_from_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_OUT))
        else $error("result without output step");
endmodule

/* rtl/iqmg_muldiv.sv */
// iqmg_muldiv: shared multiply, divide by 2047 by folding, optional divide by 100
// by reciprocal multiply; quotient truncates toward zero; depends on iqmg_pkg
module iqmg_muldiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iqmg_pkg::t_md_req i_req,
    output iqmg_pkg::t_md_rsp o_rsp
);
    import iqmg_pkg::*;

    localparam int NUM_W    = 44;
    localparam int FOLD_W   = 11;                       // 2047 = 2^11 - 1
    localparam int RECIP_SH = 27;
    localparam logic [20:0] RECIP_100 = 21'd1342178;    // ceil(2^27 / 100)

    typedef enum logic [3:0] {
        U_IDLE  = 4'b0001,
        U_MUL   = 4'b0010,
        U_FOLD  = 4'b0100,
        U_RECIP = 4'b1000
    } t_ustate;

    t_ustate            r_ustate;
    logic signed [31:0] r_a;
    logic [11:0]        r_b;
    logic               r_pct;
    logic               r_neg;
    logic [NUM_W-1:0]   r_num;    // running remainder of the fold
    logic [NUM_W-1:0]   r_quo;
    logic               r_done;

    logic signed [31:0]      w_ma;
    logic [20:0]             w_mb;
    logic signed [53:0]      w_prod;
    logic [NUM_W-FOLD_W-1:0] w_hi;
    logic                    w_fold_end;

    // one multiplier: request operands, or quotient times reciprocal of 100
    always_comb begin
        if (r_ustate == U_RECIP) begin
            w_ma = $signed(r_quo[31:0]);
            w_mb = RECIP_100;
        end else begin
            w_ma = r_a;
            w_mb = {9'd0, r_b};
        end
    end

    assign w_prod     = w_ma * $signed({1'b0, w_mb});
    assign w_hi       = r_num[NUM_W-1:FOLD_W];
    assign w_fold_end = (r_ustate == U_FOLD) && (w_hi == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ustate <= U_IDLE;
            r_done   <= 1'b0;
        end else begin
            r_done <= (w_fold_end && !r_pct) || (r_ustate == U_RECIP);
            case (r_ustate)
                U_IDLE: begin
                    if (i_req.start) begin
                        r_a      <= i_req.a;
                        r_b      <= i_req.b;
                        r_pct    <= i_req.pct;
                        r_ustate <= U_MUL;
                    end
                end
                U_MUL: begin
                    r_neg    <= w_prod[53];
                    r_num    <= w_prod[53] ? NUM_W'(-w_prod) : NUM_W'(w_prod);
                    r_quo    <= '0;
                    r_ustate <= U_FOLD;
                end
                U_FOLD: begin
                    if (!w_fold_end) begin
                        // 2^11 is 1 mod 2047: fold the high part onto the low part
                        r_quo <= r_quo + NUM_W'(w_hi);
                        r_num <= NUM_W'(r_num[FOLD_W-1:0]) + NUM_W'(w_hi);
                    end else begin
                        // remainder is now 0..2047, one last compare
                        if (r_num == NUM_W'(SINE_FULL)) r_quo <= r_quo + NUM_W'(1);
                        r_ustate <= r_pct ? U_RECIP : U_IDLE;
                    end
                end
                U_RECIP: begin
                    r_quo    <= NUM_W'(w_prod[53:RECIP_SH]);
                    r_ustate <= U_IDLE;
                end
                default: r_ustate <= U_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_neg ? -$signed(r_quo) : $signed(r_quo);
endmodule
